// ===== rtl/core/extent_run_list_decoder_core_defines.svh =====
// Assertion macros for the extent run list decoder checkers.
`ifndef EXTENT_RUN_LIST_DECODER_CORE_DEFINES_SVH
`define EXTENT_RUN_LIST_DECODER_CORE_DEFINES_SVH

// Check a property outside reset.
`define ERLD_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("erld check failed");

// Check a property at every edge, reset included.
`define ERLD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("erld check failed across reset");

`endif

// ===== rtl/core/erld_pkg.sv =====
package erld_pkg;

  // Field size limit of one run and record size log2
  localparam int MAX_FIELD_BYTES   = 8;
  localparam int RECORD_BYTES_LOG2 = 10;

  // Cluster size log2 after reset
  localparam logic [4:0] CLUSTER_LOG2_RESET = 5'd12;

  // Input item: one byte of the run list
  typedef struct packed {
    logic [7:0] run_byte;
    logic       first_byte;
    logic       area_end;
  } in_item_t;

  // Result item: one decoded run or one list close
  typedef struct packed {
    logic [63:0] run_length;
    logic [63:0] start_cluster;
    logic [63:0] start_byte_address;
    logic [63:0] record_count;
    logic        sparse_run;
    logic        list_end;
    logic        format_error;
  } out_item_t;

  // Parsed run, before cluster size scaling
  typedef struct packed {
    logic [63:0] run_length;
    logic [63:0] start_cluster;
    logic        sparse_run;
    logic        list_end;
    logic        format_error;
  } run_t;

endpackage

// ===== rtl/core/erld_parse.sv =====
module erld_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  erld_pkg::in_item_t item,
  input  logic             load,
  output logic             run_valid,
  output erld_pkg::run_t   run
);
  import erld_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_LENGTH, PH_OFFSET} phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  len_total, len_total_next;
  logic [3:0]  off_total, off_total_next;
  logic [3:0]  idx, idx_next;
  logic [63:0] len_acc, len_acc_next;
  logic [63:0] off_acc, off_acc_next;
  logic [63:0] cluster, cluster_next;
  logic        closed, closed_next;

  phase_t      eff_phase;
  logic        open;
  logic [3:0]  ln, on;
  logic [3:0]  idx_inc;
  logic [5:0]  byte_shift;
  logic [63:0] len_acc_upd, off_acc_upd;
  logic [5:0]  sign_pos;
  logic        sign_ext;
  logic [63:0] off_val;
  logic [63:0] base_cluster;
  logic [63:0] run_cluster;
  logic        do_run, do_close, close_err;
  run_t        res;
  logic        res_valid;

  // Decode the byte against the parse state
  always_comb begin
    open         = item.first_byte | ~closed;
    eff_phase    = item.first_byte ? PH_HEADER : phase;
    base_cluster = item.first_byte ? 64'd0 : cluster;
    ln           = item.run_byte[3:0];
    on           = item.run_byte[7:4];
    idx_inc      = idx + 4'd1;
    byte_shift   = {idx[2:0], 3'b000};
    len_acc_upd  = len_acc | (64'(item.run_byte) << byte_shift);
    off_acc_upd  = off_acc | (64'(item.run_byte) << byte_shift);

    // Sign-extend a short offset from its top byte
    sign_pos = {off_total[2:0] - 3'd1, 3'b111};
    sign_ext = (off_total != 4'd0) && (off_total < 4'(MAX_FIELD_BYTES)) &&
               off_acc_upd[sign_pos];
    off_val  = sign_ext ? (off_acc_upd | ({64{1'b1}} << {off_total[2:0], 3'b000}))
                        : off_acc_upd;
    run_cluster = base_cluster + ((eff_phase == PH_OFFSET) ? off_val : 64'd0);

    phase_next     = eff_phase;
    len_total_next = len_total;
    off_total_next = off_total;
    idx_next       = idx;
    len_acc_next   = len_acc;
    off_acc_next   = off_acc;
    cluster_next   = base_cluster;
    closed_next    = closed & ~item.first_byte;
    do_run         = 1'b0;
    do_close       = 1'b0;
    close_err      = 1'b0;

    if (open) begin
      case (eff_phase)
        PH_HEADER: begin
          if (item.run_byte == 8'd0) begin
            do_close = 1'b1;
          end else if (ln == 4'd0 || ln > 4'(MAX_FIELD_BYTES) ||
                       on > 4'(MAX_FIELD_BYTES) || item.area_end) begin
            do_close  = 1'b1;
            close_err = 1'b1;
          end else begin
            len_total_next = ln;
            off_total_next = on;
            idx_next       = 4'd0;
            len_acc_next   = 64'd0;
            off_acc_next   = 64'd0;
            phase_next     = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          len_acc_next = len_acc_upd;
          idx_next     = idx_inc;
          if (idx_inc >= len_total) begin
            idx_next = 4'd0;
            if (off_total == 4'd0) begin
              do_run = 1'b1;
            end else begin
              phase_next = PH_OFFSET;
              if (item.area_end) begin
                do_close  = 1'b1;
                close_err = 1'b1;
              end
            end
          end else if (item.area_end) begin
            do_close  = 1'b1;
            close_err = 1'b1;
          end
        end
        PH_OFFSET: begin
          off_acc_next = off_acc_upd;
          idx_next     = idx_inc;
          if (idx_inc >= off_total) begin
            idx_next = 4'd0;
            do_run   = 1'b1;
          end else if (item.area_end) begin
            do_close  = 1'b1;
            close_err = 1'b1;
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end

    // Build the result
    res       = '0;
    res_valid = do_run | do_close;
    if (do_run) begin
      cluster_next      = run_cluster;
      phase_next        = PH_HEADER;
      closed_next       = item.area_end;
      res.run_length    = (eff_phase == PH_LENGTH) ? len_acc_upd : len_acc;
      res.start_cluster = run_cluster;
      res.sparse_run    = (off_total == 4'd0);
      res.list_end      = item.area_end;
    end
    if (do_close) begin
      phase_next       = PH_HEADER;
      closed_next      = 1'b1;
      res.list_end     = 1'b1;
      res.format_error = close_err;
    end
  end

  // Advance state and the run register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      len_total <= 4'd0;
      off_total <= 4'd0;
      idx       <= 4'd0;
      len_acc   <= 64'd0;
      off_acc   <= 64'd0;
      cluster   <= 64'd0;
      closed    <= 1'b0;
      run_valid <= 1'b0;
    end else if (load) begin
      run_valid <= item_valid & res_valid;
      run       <= res;
      if (item_valid) begin
        phase     <= phase_next;
        len_total <= len_total_next;
        off_total <= off_total_next;
        idx       <= idx_next;
        len_acc   <= len_acc_next;
        off_acc   <= off_acc_next;
        cluster   <= cluster_next;
        closed    <= closed_next;
      end
    end
  end

endmodule

// ===== rtl/core/erld_format.sv =====
module erld_format (
  input  logic                clk,
  input  logic                rst,
  input  logic                run_valid,
  input  erld_pkg::run_t      run,
  input  logic                load,
  input  logic [4:0]          cluster_log2,
  output logic                out_valid,
  output erld_pkg::out_item_t out_item
);
  import erld_pkg::*;

  logic [63:0] run_bytes;
  out_item_t   item_next;

  // Scale the run by the cluster size
  always_comb begin
    run_bytes                    = run.run_length << cluster_log2;
    item_next.run_length         = run.run_length;
    item_next.start_cluster      = run.start_cluster;
    item_next.start_byte_address = run.start_cluster << cluster_log2;
    item_next.record_count       = run_bytes >> RECORD_BYTES_LOG2;
    item_next.sparse_run         = run.sparse_run;
    item_next.list_end           = run.list_end;
    item_next.format_error       = run.format_error;
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= run_valid;
      out_item  <= item_next;
    end
  end

endmodule

// ===== rtl/core/extent_run_list_decoder_core.sv =====
// Channel | Dir | Handshake          | Payload
// in      | in  | in_valid/in_stall  | in_item: run_byte, first_byte, area_end
// out     | out | out_valid/out_stall| out_item: run and close results
// cfg     | in  | cfg_write_en       | cfg_write_data: cluster size log2
//
// One byte is taken every cycle unless in_stall holds it; a result passes through the input
// register, parse register and output register before it shows on out_valid.
// Headers and field bytes that end no run and close no list give no result.
// Synchronous reset clears the parse state and valids, and sets the cluster size log2 to 12.
// out_stall backs up through the register chain to in_stall in the same cycle.
module extent_run_list_decoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  erld_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output erld_pkg::out_item_t out_item,
  input  logic                cfg_write_en,
  input  logic [4:0]          cfg_write_data
);
  import erld_pkg::*;

  logic       in_reg_valid;
  in_item_t   in_reg;
  logic [4:0] cluster_log2;
  logic       run_valid;
  run_t       run;
  logic       out_load, run_load, in_load;

  // Each register loads when empty or when its content moves on
  assign out_load = ~out_valid | ~out_stall;
  assign run_load = ~run_valid | out_load;
  assign in_load  = ~in_reg_valid | run_load;
  assign in_stall = ~in_load;

  // Hold the incoming item and the cluster size
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      cluster_log2 <= CLUSTER_LOG2_RESET;
    end else begin
      if (in_load) begin
        in_reg_valid <= in_valid;
        in_reg       <= in_item;
      end
      if (cfg_write_en) begin
        cluster_log2 <= cfg_write_data;
      end
    end
  end

  erld_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_reg_valid),
    .item       (in_reg),
    .load       (run_load),
    .run_valid  (run_valid),
    .run        (run)
  );

  erld_format u_format (
    .clk          (clk),
    .rst          (rst),
    .run_valid    (run_valid),
    .run          (run),
    .load         (out_load),
    .cluster_log2 (cluster_log2),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

endmodule

// ===== rtl/core/erld_checker.sv =====
`include "extent_run_list_decoder_core_defines.svh"

module erld_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input erld_pkg::out_item_t out_item
);
  import erld_pkg::*;

  logic err_fields_clear;

  // An error result sets list_end and leaves these run fields at zero
  assign err_fields_clear = out_item.list_end && out_item.run_length == 64'd0 &&
                            out_item.start_cluster == 64'd0 && !out_item.sparse_run;

  // A stalled result stays put
  `ERLD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item))

  // An error result closes the list and carries no run
  `ERLD_ASSERT(a_err_close, out_valid && out_item.format_error |-> err_fields_clear)

  // Byte address follows the cluster
  `ERLD_ASSERT(a_zero_addr, out_valid && out_item.start_cluster == 64'd0 |-> out_item.start_byte_address == 64'd0)

  // No result right after reset
  `ERLD_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid)

endmodule

bind extent_run_list_decoder_core erld_checker u_checker (.*);
